// ===== hdl/mesh_adaptive_route_with_load_assert.svh =====
// Assertion macros shared by the mesh router RTL.
`ifndef MESH_ADAPTIVE_ROUTE_WITH_LOAD_ASSERT_SVH
`define MESH_ADAPTIVE_ROUTE_WITH_LOAD_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mesh router assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mesh router assertion failed");

`endif

// ===== hdl/mar_pkg.sv =====
// Shared constants, codes and types of the mesh adaptive router.
`timescale 1ns / 1ps

package mar_pkg;

    // default mesh edge length
    localparam int EDGE = 8;

    // field widths
    localparam int CMD_BITS   = 2;
    localparam int COORD_BITS = 3;
    localparam int BW_BITS    = 20;
    localparam int DIR_BITS   = 2;
    localparam int STAT_BITS  = 3;
    localparam int USAGE_BITS = 32;

    // commands
    localparam logic [CMD_BITS-1:0] CMD_ROUTE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

    // result status codes
    localparam logic [STAT_BITS-1:0] STAT_HOP   = 3'd0;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY = 3'd1;
    localparam logic [STAT_BITS-1:0] STAT_ERROR = 3'd2;
    localparam logic [STAT_BITS-1:0] STAT_READ  = 3'd3;
    localparam logic [STAT_BITS-1:0] STAT_CLEAR = 3'd4;

    // link directions
    localparam logic [DIR_BITS-1:0] DIR_N = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_S = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_E = 2'd2;
    localparam logic [DIR_BITS-1:0] DIR_W = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [DIR_BITS-1:0]   t_dir;
    typedef logic [USAGE_BITS-1:0] t_usage;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_PICK,
        ST_STEP,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/mar_ifs.sv =====
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps

interface mar_in_if;
    logic                            valid;
    logic                            ready;
    logic [mar_pkg::CMD_BITS-1:0]    command;
    logic [mar_pkg::COORD_BITS-1:0]  src_row;
    logic [mar_pkg::COORD_BITS-1:0]  src_col;
    logic [mar_pkg::COORD_BITS-1:0]  dst_row;
    logic [mar_pkg::COORD_BITS-1:0]  dst_col;
    logic [mar_pkg::BW_BITS-1:0]     bandwidth;
    logic [mar_pkg::DIR_BITS-1:0]    read_dir;

    modport source (
        output valid, command, src_row, src_col, dst_row, dst_col, bandwidth, read_dir,
        input  ready
    );
    modport sink (
        input  valid, command, src_row, src_col, dst_row, dst_col, bandwidth, read_dir,
        output ready
    );
endinterface

interface mar_out_if;
    logic                            valid;
    logic                            ready;
    logic [mar_pkg::STAT_BITS-1:0]   status;
    logic [mar_pkg::COORD_BITS-1:0]  hop_row;
    logic [mar_pkg::COORD_BITS-1:0]  hop_col;
    logic [mar_pkg::DIR_BITS-1:0]    direction;
    logic [mar_pkg::USAGE_BITS-1:0]  usage_value;
    logic                            last;

    modport source (
        output valid, status, hop_row, hop_col, direction, usage_value, last,
        input  ready
    );
    modport sink (
        input  valid, status, hop_row, hop_col, direction, usage_value, last,
        output ready
    );
endinterface

// ===== hdl/mar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mesh_adaptive_route_with_load.sv =====
// Sequencing: a route passes through the wait, pick and step states for each hop; a read
// goes through wait and read, and clear, empty and off-mesh commands go straight to emit.
// One command at a time: the next is taken only after the last word of the previous one is
// registered, and the result side can stall the step, read and emit states. The single
// counter RAM port and the shared comparator set the pace. Reset is synchronous, active low;
// per-router valid flags clear at once, so all counters read zero with no clearing pass.
`timescale 1ns / 1ps
`include "mesh_adaptive_route_with_load_assert.svh"

module mesh_adaptive_route_with_load #(
    parameter int EDGE = mar_pkg::EDGE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    mar_in_if.sink     i_in,
    mar_out_if.source  o_out
);

    localparam int ROUTERS   = EDGE * EDGE;
    localparam int ADDR_BITS = $clog2(ROUTERS);
    localparam int UB        = mar_pkg::USAGE_BITS;
    localparam int ROW_BITS  = 4 * UB;
    localparam logic [4:0] EDGE_V = 5'(EDGE);

    // router index in the counter RAM
    function automatic logic [ADDR_BITS-1:0] f_addr(input mar_pkg::t_coord r,
                                                     input mar_pkg::t_coord c);
        return ADDR_BITS'(ADDR_BITS'(r) * ADDR_BITS'(EDGE)) + ADDR_BITS'(c);
    endfunction

    function automatic logic f_off(input mar_pkg::t_coord c);
        return {2'b00, c} >= EDGE_V;
    endfunction

    // one counter of a router row
    function automatic mar_pkg::t_usage f_cnt(input logic [ROW_BITS-1:0] row,
                                              input mar_pkg::t_dir d);
        return row[UB * int'(d) +: UB];
    endfunction

    // control registers
    mar_pkg::t_state         r_state, n_state;
    logic                    r_turn;
    logic [ROUTERS-1:0]      r_valid, n_valid;
    logic                    r_out_valid;

    // payload registers
    logic [ADDR_BITS-1:0]    r_addr, n_addr;
    mar_pkg::t_coord         r_pos_row, n_pos_row, r_pos_col, n_pos_col;
    mar_pkg::t_coord         r_dst_row, n_dst_row, r_dst_col, n_dst_col;
    mar_pkg::t_coord         r_src_col, n_src_col;
    logic [mar_pkg::BW_BITS-1:0] r_bw, n_bw;
    mar_pkg::t_dir           r_rdir, n_rdir;
    logic                    r_is_read, n_is_read;
    mar_pkg::t_dir           r_dir, n_dir;
    logic                    r_err, n_err;
    mar_pkg::t_usage         r_old, n_old;
    logic [ROW_BITS-1:0]     r_row, n_row;
    logic [mar_pkg::STAT_BITS-1:0] r_pend_stat, n_pend_stat;
    logic [mar_pkg::STAT_BITS-1:0] r_out_stat, n_out_stat;
    mar_pkg::t_coord         r_out_row, n_out_row, r_out_col, n_out_col;
    mar_pkg::t_dir           r_out_dir, n_out_dir;
    mar_pkg::t_usage         r_out_val, n_out_val;
    logic                    r_out_last, n_out_last;

    // combinational signals
    logic                    w_accept, w_out_free, out_load;
    logic                    w_src_off, w_route_off, w_same;
    mar_pkg::t_coord         w_next_row, w_next_col;
    logic                    w_hop_last, w_pos_ok;
    logic [ROW_BITS-1:0]     w_rdata, w_row_m, ram_wdata;
    logic                    ram_we;
    mar_pkg::t_dir           w_vert, w_pick;
    logic                    w_pick_err, w_west_bound;
    mar_pkg::t_usage         w_cmp_a, w_cmp_b;
    logic                    w_lt, w_eq, w_v_ok, w_e_ok;
    mar_pkg::t_coord         w_dcol, w_drow;
    logic [UB:0]             w_sum;
    mar_pkg::t_usage         w_sat;

    // counter RAM: one row of four link counters per router
    mar_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROUTERS)
    ) u_usage_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // handshake and command decode
    assign i_in.ready  = (r_state == mar_pkg::ST_IDLE) && i_rst_n;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_src_off   = f_off(i_in.src_row) || f_off(i_in.src_col);
    assign w_route_off = w_src_off || f_off(i_in.dst_row) || f_off(i_in.dst_col);
    assign w_same      = (i_in.src_row == i_in.dst_row) && (i_in.src_col == i_in.dst_col);
    assign w_pos_ok    = ({2'b00, r_pos_row} < EDGE_V) && ({2'b00, r_pos_col} < EDGE_V);

    // never-written routers read as zero
    assign w_row_m = r_valid[r_addr] ? w_rdata : '0;

    // position after the chosen hop
    always_comb begin
        w_next_row = r_pos_row;
        w_next_col = r_pos_col;
        case (r_dir)
            mar_pkg::DIR_N: w_next_row = r_pos_row + 3'd1;
            mar_pkg::DIR_S: w_next_row = r_pos_row - 3'd1;
            mar_pkg::DIR_E: w_next_col = r_pos_col + 3'd1;
            mar_pkg::DIR_W: w_next_col = r_pos_col - 3'd1;
            default: w_next_row = r_pos_row;
        endcase
    end
    assign w_hop_last = (w_next_row == r_dst_row) && (w_next_col == r_dst_col);

    // shared comparator: vertical vs east, or west vs vertical when westbound
    assign w_vert       = (r_pos_row < r_dst_row) ? mar_pkg::DIR_N : mar_pkg::DIR_S;
    assign w_west_bound = r_pos_col > r_dst_col;
    assign w_cmp_a      = w_west_bound ? f_cnt(w_row_m, mar_pkg::DIR_W)
                                       : f_cnt(w_row_m, w_vert);
    assign w_cmp_b      = w_west_bound ? f_cnt(w_row_m, w_vert)
                                       : f_cnt(w_row_m, mar_pkg::DIR_E);
    assign w_lt         = w_cmp_a < w_cmp_b;
    assign w_eq         = w_cmp_a == w_cmp_b;
    assign w_dcol       = r_dst_col - r_pos_col;
    assign w_drow       = (w_vert == mar_pkg::DIR_N) ? (r_dst_row - r_pos_row)
                                                    : (r_pos_row - r_dst_row);
    assign w_v_ok       = r_pos_col[0] || (r_pos_col == r_src_col);
    assign w_e_ok       = r_dst_col[0] || (w_dcol != 3'd1);

    // turn model decision
    always_comb begin
        w_pick     = w_vert;
        w_pick_err = 1'b0;
        if (!r_turn) begin
            // west-first
            if (w_west_bound) begin
                w_pick = mar_pkg::DIR_W;
            end else if (r_pos_col == r_dst_col) begin
                w_pick = w_vert;
            end else if (r_pos_row == r_dst_row) begin
                w_pick = mar_pkg::DIR_E;
            end else if (w_lt) begin
                w_pick = w_vert;
            end else if (w_eq) begin
                w_pick = (w_dcol <= w_drow) ? w_vert : mar_pkg::DIR_E;
            end else begin
                w_pick = mar_pkg::DIR_E;
            end
        end else begin
            // odd-even
            if (r_pos_col == r_dst_col) begin
                w_pick = w_vert;
            end else if (!w_west_bound) begin
                if (r_pos_row == r_dst_row) begin
                    w_pick = mar_pkg::DIR_E;
                end else if (!w_v_ok && !w_e_ok) begin
                    w_pick_err = 1'b1;
                end else if (!w_v_ok) begin
                    w_pick = mar_pkg::DIR_E;
                end else if (!w_e_ok) begin
                    w_pick = w_vert;
                end else begin
                    w_pick = w_lt ? w_vert : mar_pkg::DIR_E;
                end
            end else if (r_pos_col[0] || (r_pos_row == r_dst_row)) begin
                w_pick = mar_pkg::DIR_W;
            end else begin
                w_pick = w_lt ? mar_pkg::DIR_W : w_vert;
            end
        end
    end

    // saturating counter update
    assign w_sum = {1'b0, r_old} + {{(UB + 1 - mar_pkg::BW_BITS){1'b0}}, r_bw};
    assign w_sat = w_sum[UB] ? '1 : w_sum[UB-1:0];
    always_comb begin
        ram_wdata = r_row;
        ram_wdata[UB * int'(r_dir) +: UB] = w_sat;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mar_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.command)
                        mar_pkg::CMD_CLEAR: n_state = mar_pkg::ST_EMIT;
                        mar_pkg::CMD_READ:
                            n_state = w_src_off ? mar_pkg::ST_EMIT : mar_pkg::ST_WAIT;
                        mar_pkg::CMD_ROUTE:
                            n_state = (w_route_off || w_same) ? mar_pkg::ST_EMIT
                                                              : mar_pkg::ST_WAIT;
                        default: n_state = mar_pkg::ST_IDLE;
                    endcase
                end
            end
            mar_pkg::ST_WAIT: n_state = r_is_read ? mar_pkg::ST_READ : mar_pkg::ST_PICK;
            mar_pkg::ST_PICK: n_state = mar_pkg::ST_STEP;
            mar_pkg::ST_STEP: begin
                if (w_out_free) begin
                    n_state = (r_err || w_hop_last) ? mar_pkg::ST_IDLE : mar_pkg::ST_WAIT;
                end
            end
            mar_pkg::ST_READ, mar_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = mar_pkg::ST_IDLE;
                end
            end
            default: n_state = mar_pkg::ST_IDLE;
        endcase
    end

    // datapath and result word
    always_comb begin
        n_valid     = r_valid;
        n_addr      = r_addr;
        n_pos_row   = r_pos_row;
        n_pos_col   = r_pos_col;
        n_dst_row   = r_dst_row;
        n_dst_col   = r_dst_col;
        n_src_col   = r_src_col;
        n_bw        = r_bw;
        n_rdir      = r_rdir;
        n_is_read   = r_is_read;
        n_dir       = r_dir;
        n_err       = r_err;
        n_old       = r_old;
        n_row       = r_row;
        n_pend_stat = r_pend_stat;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        n_out_stat  = r_out_stat;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_dir   = r_out_dir;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        case (r_state)
            mar_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_pos_row = i_in.src_row;
                    n_pos_col = i_in.src_col;
                    n_dst_row = i_in.dst_row;
                    n_dst_col = i_in.dst_col;
                    n_src_col = i_in.src_col;
                    n_bw      = i_in.bandwidth;
                    n_rdir    = i_in.read_dir;
                    case (i_in.command)
                        mar_pkg::CMD_CLEAR: begin
                            n_valid     = '0;
                            n_pos_row   = '0;
                            n_pos_col   = '0;
                            n_pend_stat = mar_pkg::STAT_CLEAR;
                        end
                        mar_pkg::CMD_READ: begin
                            n_is_read   = 1'b1;
                            n_pend_stat = mar_pkg::STAT_ERROR;
                            if (!w_src_off) begin
                                n_addr = f_addr(i_in.src_row, i_in.src_col);
                            end
                        end
                        mar_pkg::CMD_ROUTE: begin
                            n_is_read   = 1'b0;
                            n_pend_stat = w_route_off ? mar_pkg::STAT_ERROR
                                                      : mar_pkg::STAT_EMPTY;
                            if (!w_route_off && !w_same) begin
                                n_addr = f_addr(i_in.src_row, i_in.src_col);
                            end
                        end
                        default: n_is_read = r_is_read;
                    endcase
                end
            end
            mar_pkg::ST_PICK: begin
                n_dir = w_pick;
                n_err = w_pick_err;
                n_old = f_cnt(w_row_m, w_pick);
                n_row = w_row_m;
            end
            mar_pkg::ST_STEP: begin
                if (w_out_free) begin
                    out_load  = 1'b1;
                    n_out_row = r_pos_row;
                    n_out_col = r_pos_col;
                    n_out_val = '0;
                    if (r_err) begin
                        // stuck router: no legal turn
                        n_out_stat = mar_pkg::STAT_ERROR;
                        n_out_dir  = mar_pkg::DIR_N;
                        n_out_last = 1'b1;
                    end else begin
                        ram_we           = 1'b1;
                        n_valid[r_addr]  = 1'b1;
                        n_out_stat       = mar_pkg::STAT_HOP;
                        n_out_dir        = r_dir;
                        n_out_last       = w_hop_last;
                        n_pos_row        = w_next_row;
                        n_pos_col        = w_next_col;
                        if (!w_hop_last) begin
                            n_addr = f_addr(w_next_row, w_next_col);
                        end
                    end
                end
            end
            mar_pkg::ST_READ: begin
                if (w_out_free) begin
                    out_load   = 1'b1;
                    n_out_stat = mar_pkg::STAT_READ;
                    n_out_row  = r_pos_row;
                    n_out_col  = r_pos_col;
                    n_out_dir  = r_rdir;
                    n_out_val  = f_cnt(w_row_m, r_rdir);
                    n_out_last = 1'b1;
                end
            end
            mar_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    out_load   = 1'b1;
                    n_out_stat = r_pend_stat;
                    n_out_row  = r_pos_row;
                    n_out_col  = r_pos_col;
                    n_out_dir  = mar_pkg::DIR_N;
                    n_out_val  = '0;
                    n_out_last = 1'b1;
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mar_pkg::ST_IDLE;
            r_turn      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_turn <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pos_row   <= n_pos_row;
        r_pos_col   <= n_pos_col;
        r_dst_row   <= n_dst_row;
        r_dst_col   <= n_dst_col;
        r_src_col   <= n_src_col;
        r_bw        <= n_bw;
        r_rdir      <= n_rdir;
        r_is_read   <= n_is_read;
        r_dir       <= n_dir;
        r_err       <= n_err;
        r_old       <= n_old;
        r_row       <= n_row;
        r_pend_stat <= n_pend_stat;
        r_out_stat  <= n_out_stat;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_dir   <= n_out_dir;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
    end

    // result port
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_stat;
    assign o_out.hop_row     = r_out_row;
    assign o_out.hop_col     = r_out_col;
    assign o_out.direction   = r_out_dir;
    assign o_out.usage_value = r_out_val;
    assign o_out.last        = r_out_last;

    // checks
    `MAR_ASSERT_IMP(a_ram_we_step, i_clk, i_rst_n, ram_we, (r_state == mar_pkg::ST_STEP) && !r_err)
    `MAR_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load, w_out_free)
    `MAR_ASSERT_NXT(a_clear_valid, i_clk, i_rst_n, w_accept && (i_in.command == mar_pkg::CMD_CLEAR), r_valid == '0)
    `MAR_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, out_load && n_out_last, r_state == mar_pkg::ST_IDLE)
    `MAR_ASSERT_IMP(a_walk_on_mesh, i_clk, i_rst_n, r_state == mar_pkg::ST_PICK, w_pos_ok)

endmodule

// ===== sim/tb_mesh_adaptive_route_with_load.sv =====
// Self-checking testbench for the adaptive mesh router: directed table, then random commands.
`timescale 1ns / 1ps

module tb_mesh_adaptive_route_with_load;

    typedef logic [mar_pkg::CMD_BITS-1:0]  t_op;
    typedef logic [mar_pkg::STAT_BITS-1:0] t_stat;
    typedef logic [mar_pkg::BW_BITS-1:0]   t_bw;

    localparam int          HALF_NS    = 5;
    localparam int          LIMIT_NS   = 5_000_000;
    localparam int          SETTLE     = 8;
    localparam int          PHASE_CMDS = 24;
    localparam int          HOLD_LONG  = 150;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [2:0]  NO_TURN    = 3'd4;
    localparam bit          WF         = 1'b0;
    localparam bit          OE         = 1'b1;

    typedef struct packed {
        t_op                 command;
        mar_pkg::t_coord     src_row;
        mar_pkg::t_coord     src_col;
        mar_pkg::t_coord     dst_row;
        mar_pkg::t_coord     dst_col;
        t_bw                 bandwidth;
        mar_pkg::t_dir       read_dir;
    } t_cmd;

    typedef struct packed {
        t_stat               status;
        mar_pkg::t_coord     hop_row;
        mar_pkg::t_coord     hop_col;
        mar_pkg::t_dir       direction;
        mar_pkg::t_usage     usage_value;
        logic                last;
    } t_word;

    // one line of the directed table; pinned rows carry a hand-written expectation
    typedef struct packed {
        t_cmd  c;
        bit    model;
        bit    pinned;
        t_word want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    mar_in_if  cmd_ch ();
    mar_out_if res_ch ();

    mesh_adaptive_route_with_load dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    // predictor state: link load counters and the turn model copy
    mar_pkg::t_usage load_tab [mar_pkg::EDGE*mar_pkg::EDGE*4];
    bit     oe_mode = 1'b0;

    t_word  pending_words [$];
    int     mismatch_cnt = 0;
    bit     idling = 1'b1;
    int     hold_cycles = 0;
    bit     pin_on = 1'b0;
    t_word  pin_word = '0;
    mar_pkg::t_coord recent_row = '0;
    mar_pkg::t_coord recent_col = '0;

    always #HALF_NS i_clk = ~i_clk;

    function automatic int lidx(mar_pkg::t_coord r, mar_pkg::t_coord c, mar_pkg::t_dir d);
        return (int'(r) * mar_pkg::EDGE + int'(c)) * 4 + int'(d);
    endfunction

    function automatic t_word word(t_stat st, mar_pkg::t_coord r, mar_pkg::t_coord c,
                                   mar_pkg::t_dir d, mar_pkg::t_usage v, logic l);
        t_word w;
        w.status      = st;
        w.hop_row     = r;
        w.hop_col     = c;
        w.direction   = d;
        w.usage_value = v;
        w.last        = l;
        return w;
    endfunction

    function automatic t_cmd mk_cmd(t_op cmd, mar_pkg::t_coord sr, mar_pkg::t_coord sc,
                                    mar_pkg::t_coord dr, mar_pkg::t_coord dc, t_bw bw,
                                    mar_pkg::t_dir rd);
        t_cmd c;
        c.command   = cmd;
        c.src_row   = sr;
        c.src_col   = sc;
        c.dst_row   = dr;
        c.dst_col   = dc;
        c.bandwidth = bw;
        c.read_dir  = rd;
        return c;
    endfunction

    function automatic t_row free(bit m, t_op cmd, mar_pkg::t_coord sr, mar_pkg::t_coord sc,
                                  mar_pkg::t_coord dr, mar_pkg::t_coord dc, t_bw bw,
                                  mar_pkg::t_dir rd);
        t_row row;
        row.c      = mk_cmd(cmd, sr, sc, dr, dc, bw, rd);
        row.model  = m;
        row.pinned = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic t_row pin(bit m, t_op cmd, mar_pkg::t_coord sr, mar_pkg::t_coord sc,
                                 mar_pkg::t_coord dr, mar_pkg::t_coord dc, t_bw bw,
                                 mar_pkg::t_dir rd, t_stat st, mar_pkg::t_coord hr,
                                 mar_pkg::t_coord hc, mar_pkg::t_dir hd,
                                 mar_pkg::t_usage v);
        t_row row;
        row        = free(m, cmd, sr, sc, dr, dc, bw, rd);
        row.pinned = 1'b1;
        row.want   = word(st, hr, hc, hd, v, 1'b1);
        return row;
    endfunction

    // next output link under the active turn model, NO_TURN when none is legal
    function automatic logic [2:0] pick_dir(mar_pkg::t_coord r, mar_pkg::t_coord c,
                                            mar_pkg::t_coord sc, mar_pkg::t_coord dr,
                                            mar_pkg::t_coord dc);
        mar_pkg::t_dir   vert;
        mar_pkg::t_usage uv;
        mar_pkg::t_usage ue;
        int     dcol;
        int     drow;
        bit     v_ok;
        bit     e_ok;
        vert = (r < dr) ? mar_pkg::DIR_N : mar_pkg::DIR_S;
        uv   = load_tab[lidx(r, c, vert)];
        ue   = load_tab[lidx(r, c, mar_pkg::DIR_E)];
        if (!oe_mode) begin
            if (c > dc) return {1'b0, mar_pkg::DIR_W};
            if (c == dc) return {1'b0, vert};
            if (r == dr) return {1'b0, mar_pkg::DIR_E};
            dcol = int'(dc) - int'(c);
            drow = (r < dr) ? int'(dr) - int'(r) : int'(r) - int'(dr);
            if (uv < ue) return {1'b0, vert};
            if (uv > ue) return {1'b0, mar_pkg::DIR_E};
            return (dcol <= drow) ? {1'b0, vert} : {1'b0, mar_pkg::DIR_E};
        end
        if (c == dc) return {1'b0, vert};
        if (c < dc) begin
            if (r == dr) return {1'b0, mar_pkg::DIR_E};
            v_ok = c[0] || (c == sc);
            e_ok = dc[0] || ((int'(dc) - int'(c)) != 1);
            if (!v_ok && !e_ok) return NO_TURN;
            if (!v_ok) return {1'b0, mar_pkg::DIR_E};
            if (!e_ok) return {1'b0, vert};
            return (uv < ue) ? {1'b0, vert} : {1'b0, mar_pkg::DIR_E};
        end
        // westbound: even columns off the destination row may choose
        if (c[0] || r == dr) return {1'b0, mar_pkg::DIR_W};
        return (load_tab[lidx(r, c, mar_pkg::DIR_W)] < uv) ? {1'b0, mar_pkg::DIR_W}
                                                             : {1'b0, vert};
    endfunction

    // apply one command to the predictor and queue the words it should produce
    task automatic forecast_command(input t_cmd c);
        mar_pkg::t_coord r;
        mar_pkg::t_coord col;
        logic [2:0] d;
        t_word      held;
        bit         have;
        int         k;
        int         i;
        logic [32:0] sum;
        d    = '0;
        have = 1'b0;
        held = '0;
        case (c.command)
            mar_pkg::CMD_CLEAR: begin
                foreach (load_tab[j]) load_tab[j] = '0;
                pending_words.push_back(word(mar_pkg::STAT_CLEAR, '0, '0, mar_pkg::DIR_N,
                                             '0, 1'b1));
            end
            mar_pkg::CMD_READ: begin
                if (c.src_row >= mar_pkg::EDGE || c.src_col >= mar_pkg::EDGE)
                    pending_words.push_back(word(mar_pkg::STAT_ERROR, c.src_row, c.src_col,
                                                 mar_pkg::DIR_N, '0, 1'b1));
                else
                    pending_words.push_back(word(mar_pkg::STAT_READ, c.src_row, c.src_col,
                        c.read_dir, load_tab[lidx(c.src_row, c.src_col, c.read_dir)], 1'b1));
            end
            mar_pkg::CMD_ROUTE: begin
                if (c.src_row >= mar_pkg::EDGE || c.src_col >= mar_pkg::EDGE ||
                    c.dst_row >= mar_pkg::EDGE || c.dst_col >= mar_pkg::EDGE) begin
                    pending_words.push_back(word(mar_pkg::STAT_ERROR, c.src_row, c.src_col,
                                                 mar_pkg::DIR_N, '0, 1'b1));
                end else if (c.src_row == c.dst_row && c.src_col == c.dst_col) begin
                    pending_words.push_back(word(mar_pkg::STAT_EMPTY, c.src_row, c.src_col,
                                                 mar_pkg::DIR_N, '0, 1'b1));
                end else begin
                    r   = c.src_row;
                    col = c.src_col;
                    k   = 0;
                    while ((r != c.dst_row || col != c.dst_col) &&
                           k < 2 * (mar_pkg::EDGE - 1)) begin
                        d = pick_dir(r, col, c.src_col, c.dst_row, c.dst_col);
                        if (d == NO_TURN) break;
                        // saturating add on the used link
                        i   = lidx(r, col, d[1:0]);
                        sum = {1'b0, load_tab[i]} + 33'(c.bandwidth);
                        load_tab[i] = sum[32] ? '1 : sum[31:0];
                        if (have) pending_words.push_back(held);
                        held = word(mar_pkg::STAT_HOP, r, col, d[1:0], '0, 1'b0);
                        have = 1'b1;
                        k++;
                        case (d[1:0])
                            mar_pkg::DIR_N: r   = r + 1'b1;
                            mar_pkg::DIR_S: r   = r - 1'b1;
                            mar_pkg::DIR_E: col = col + 1'b1;
                            default:        col = col - 1'b1;
                        endcase
                    end
                    if (d == NO_TURN) begin
                        if (have) pending_words.push_back(held);
                        pending_words.push_back(word(mar_pkg::STAT_ERROR, r, col,
                                                     mar_pkg::DIR_N, '0, 1'b1));
                    end else begin
                        held.last = 1'b1;
                        pending_words.push_back(held);
                    end
                end
            end
            default: ;  // unused command code: no word
        endcase
    endtask

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag(what, got, want);
    endtask

    // predict on every accepted command word
    always @(posedge i_clk) begin : cmd_watch
        int   n;
        t_cmd c;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c = mk_cmd(cmd_ch.command, cmd_ch.src_row, cmd_ch.src_col, cmd_ch.dst_row,
                       cmd_ch.dst_col, cmd_ch.bandwidth, cmd_ch.read_dir);
            n = pending_words.size();
            forecast_command(c);
            if (pin_on) begin
                while (pending_words.size() > n) void'(pending_words.pop_back());
                pending_words.push_back(pin_word);
            end
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin : res_watch
        t_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_words.size() == 0) begin
                flag("unexpected word, status", 32'(res_ch.status), '0);
            end else begin
                want = pending_words.pop_front();
                check_field("status",      32'(res_ch.status),    32'(want.status));
                check_field("hop_row",     32'(res_ch.hop_row),   32'(want.hop_row));
                check_field("hop_col",     32'(res_ch.hop_col),   32'(want.hop_col));
                check_field("direction",   32'(res_ch.direction), 32'(want.direction));
                check_field("usage_value", res_ch.usage_value,    want.usage_value);
                check_field("last",        32'(res_ch.last),      32'(want.last));
            end
        end
    end

    // result side: random stalls per word, plus a long hold when asked
    initial begin : res_drive
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles != 0) begin
                res_ch.ready = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            stall = idling ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    // offer one command word; entered and left at a falling edge
    task automatic send_cmd(input t_cmd c, input bit pinned, input t_word want);
        int gap;
        gap = idling ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.command   = c.command;
        cmd_ch.src_row   = c.src_row;
        cmd_ch.src_col   = c.src_col;
        cmd_ch.dst_row   = c.dst_row;
        cmd_ch.dst_col   = c.dst_col;
        cmd_ch.bandwidth = c.bandwidth;
        cmd_ch.read_dir  = c.read_dir;
        pin_on           = pinned;
        pin_word         = want;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_row(input t_row row);
        send_cmd(row.c, row.pinned, row.want);
    endtask

    // stop offering and wait until every expected word is back
    task automatic drain();
        cmd_ch.valid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_turn_model(input bit v);
        i_cfg_wdata = v;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        oe_mode     = v;
    endtask

    // mostly routes with biased bandwidth, some reads near recent traffic, some noise
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   roll;
        c = mk_cmd(mar_pkg::CMD_ROUTE, mar_pkg::t_coord'($urandom),
                   mar_pkg::t_coord'($urandom), mar_pkg::t_coord'($urandom),
                   mar_pkg::t_coord'($urandom), t_bw'($urandom), mar_pkg::t_dir'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            if ($urandom_range(0, 7) == 0) begin
                c.dst_row = c.src_row;
                c.dst_col = c.src_col;
            end
            case ($urandom_range(0, 3))
                0:       c.bandwidth = '0;
                1:       c.bandwidth = t_bw'($urandom_range(1, 15));
                2:       c.bandwidth = '1;
                default: ;
            endcase
            recent_row = c.src_row;
            recent_col = c.src_col;
        end else if (roll < 85) begin
            c.command = mar_pkg::CMD_READ;
            if ($urandom_range(0, 1) == 1) begin
                c.src_row = recent_row;
                c.src_col = recent_col;
            end
        end else if (roll < 92) begin
            c.command = mar_pkg::CMD_CLEAR;
        end else begin
            c.command = CMD_UNUSED;
        end
        return c;
    endfunction

    initial begin : stimulus
        t_row directed [$];
        t_cmd c;
        int   done;
        foreach (load_tab[j]) load_tab[j] = '0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = mar_pkg::CMD_ROUTE;
        cmd_ch.src_row   = '0;
        cmd_ch.src_col   = '0;
        cmd_ch.dst_row   = '0;
        cmd_ch.dst_col   = '0;
        cmd_ch.bandwidth = '0;
        cmd_ch.read_dir  = mar_pkg::DIR_N;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{
            // counters read zero after reset
            pin (WF, mar_pkg::CMD_READ, 3'd0, 3'd0, 3'd0, 3'd0, '0, mar_pkg::DIR_N,
                 mar_pkg::STAT_READ, 3'd0, 3'd0, mar_pkg::DIR_N, '0),
            pin (WF, mar_pkg::CMD_READ, 3'd7, 3'd7, 3'd7, 3'd7, '1, mar_pkg::DIR_W,
                 mar_pkg::STAT_READ, 3'd7, 3'd7, mar_pkg::DIR_W, '0),
            // source equals destination
            pin (WF, mar_pkg::CMD_ROUTE, 3'd3, 3'd3, 3'd3, 3'd3, '1, mar_pkg::DIR_S,
                 mar_pkg::STAT_EMPTY, 3'd3, 3'd3, mar_pkg::DIR_N, '0),
            // single east hop with full bandwidth, then read it back
            pin (WF, mar_pkg::CMD_ROUTE, 3'd0, 3'd0, 3'd0, 3'd1, '1, mar_pkg::DIR_N,
                 mar_pkg::STAT_HOP, 3'd0, 3'd0, mar_pkg::DIR_E, '0),
            pin (WF, mar_pkg::CMD_READ, 3'd0, 3'd0, 3'd0, 3'd0, '0, mar_pkg::DIR_E,
                 mar_pkg::STAT_READ, 3'd0, 3'd0, mar_pkg::DIR_E, 32'h000F_FFFF),
            // corner to corner, all four quadrants
            free(WF, mar_pkg::CMD_ROUTE, 3'd0, 3'd0, 3'd7, 3'd7, 20'd1, mar_pkg::DIR_N),
            free(WF, mar_pkg::CMD_ROUTE, 3'd7, 3'd7, 3'd0, 3'd0, '1, mar_pkg::DIR_N),
            free(WF, mar_pkg::CMD_ROUTE, 3'd7, 3'd0, 3'd0, 3'd7, 20'd5, mar_pkg::DIR_N),
            free(WF, mar_pkg::CMD_ROUTE, 3'd0, 3'd7, 3'd7, 3'd0, 20'd5, mar_pkg::DIR_N),
            // zero bandwidth keeps loads tied: distance tie-break decides
            free(WF, mar_pkg::CMD_ROUTE, 3'd2, 3'd2, 3'd5, 3'd5, '0, mar_pkg::DIR_N),
            free(WF, mar_pkg::CMD_ROUTE, 3'd1, 3'd1, 3'd2, 3'd6, '0, mar_pkg::DIR_N),
            // unused command code is dropped
            free(WF, CMD_UNUSED, 3'd7, 3'd7, 3'd7, 3'd7, '1, mar_pkg::DIR_W),
            pin (WF, mar_pkg::CMD_CLEAR, 3'd0, 3'd0, 3'd0, 3'd0, '0, mar_pkg::DIR_N,
                 mar_pkg::STAT_CLEAR, 3'd0, 3'd0, mar_pkg::DIR_N, '0),
            pin (WF, mar_pkg::CMD_READ, 3'd0, 3'd0, 3'd0, 3'd0, '0, mar_pkg::DIR_E,
                 mar_pkg::STAT_READ, 3'd0, 3'd0, mar_pkg::DIR_E, '0),
            free(WF, mar_pkg::CMD_ROUTE, 3'd4, 3'd1, 3'd1, 3'd6, 20'd7, mar_pkg::DIR_N),
            // odd-even: eastbound and westbound, odd and even columns
            free(OE, mar_pkg::CMD_ROUTE, 3'd0, 3'd0, 3'd7, 3'd7, 20'd3, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd7, 3'd7, 3'd0, 3'd0, 20'd3, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd1, 3'd2, 3'd4, 3'd3, 20'd2, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd1, 3'd2, 3'd4, 3'd4, 20'd2, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd0, 3'd3, 3'd5, 3'd0, 20'd9, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd5, 3'd4, 3'd0, 3'd1, 20'd9, mar_pkg::DIR_N),
            free(OE, mar_pkg::CMD_ROUTE, 3'd6, 3'd6, 3'd6, 3'd1, 20'd9, mar_pkg::DIR_N),
            pin (OE, mar_pkg::CMD_ROUTE, 3'd2, 3'd5, 3'd2, 3'd5, 20'd1, mar_pkg::DIR_N,
                 mar_pkg::STAT_EMPTY, 3'd2, 3'd5, mar_pkg::DIR_N, '0),
            free(OE, mar_pkg::CMD_READ, 3'd7, 3'd7, 3'd0, 3'd0, '0, mar_pkg::DIR_S),
            pin (OE, mar_pkg::CMD_CLEAR, 3'd7, 3'd7, 3'd7, 3'd7, '1, mar_pkg::DIR_W,
                 mar_pkg::STAT_CLEAR, 3'd0, 3'd0, mar_pkg::DIR_N, '0)
        };

        foreach (directed[i]) begin
            if (directed[i].model != oe_mode) begin
                drain();
                set_turn_model(directed[i].model);
            end
            send_row(directed[i]);
        end

        // random phases, alternating turn model
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            set_turn_model(ph[0]);
            idling = (ph != 3);
            if (ph == 1) hold_cycles = HOLD_LONG;
            done = 0;
            while (done < PHASE_CMDS) begin
                c = rand_cmd();
                send_cmd(c, 1'b0, '0);
                if (c.command != CMD_UNUSED) begin
                    done++;
                    if (ph == 2 && done == PHASE_CMDS / 2) drain();
                end
            end
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (pending_words.size() != 0)
            flag("words never returned", 32'(pending_words.size()), '0);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mar_pkg.sv
hdl/mar_ifs.sv
hdl/mar_ram.sv
hdl/mesh_adaptive_route_with_load.sv
sim/tb_mesh_adaptive_route_with_load.sv
